[hw/rtl/esp_pkg.sv]
`timescale 1ns / 1ps
package esp_pkg;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_RESULT
    } state_t;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned CFG_ADDR_W = 5;

    // register byte addresses
    localparam logic [CFG_ADDR_W-1:0] ADDR_FIRST_JERK   = 5'd0;
    localparam logic [CFG_ADDR_W-1:0] ADDR_FIRST_TARGET = 5'd4;
    localparam logic [CFG_ADDR_W-1:0] ADDR_BOUNDARY     = 5'd8;
    localparam logic [CFG_ADDR_W-1:0] ADDR_FINAL_SPEED  = 5'd12;
    localparam logic [CFG_ADDR_W-1:0] ADDR_SECOND_ACCEL = 5'd16;

    // saturate a 34-bit signed sum to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        begin
            if (v > 34'sh0_7FFF_FFFF)
                r = 32'sh7FFF_FFFF;
            else if (v < -34'sh0_8000_0000)
                r = 32'sh8000_0000;
            else
                r = v[31:0];
            return r;
        end
    endfunction

endpackage

[hw/rtl/esp_divider.sv]
`timescale 1ns / 1ps
// restoring divider: 64-bit dividend by 33-bit divisor, one quotient bit per cycle
module esp_divider (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [32:0] divisor,
    output logic        done,
    output logic [63:0] quotient
);

    logic [63:0] quo_reg, quo_next;
    logic [32:0] rem_reg, rem_next;
    logic [32:0] dvs_reg, dvs_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [33:0] shifted;
    logic [34:0] trial;

    // one shift-subtract step
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        shifted   = {rem_reg, quo_reg[63]};
        trial     = {1'b0, shifted} - {2'b00, dvs_reg};
        done      = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = 7'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[34])
            begin
                rem_next = trial[32:0];
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[32:0];
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63)
            begin
                busy_next = 1'b0;
                done      = 1'b1;
            end
        end
    end

    assign quotient = quo_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

endmodule

[hw/rtl/emergency_stop_scurve_profile_core.sv]
`timescale 1ns / 1ps
// rearm, phase-one and final ticks go straight to the result state; a phase-two tick
// squares the target in the multiply state, loads the divider, then runs 64 divider steps
// throughput: one tick at a time; in_stall stays high until the result is transferred
// reset: asynchronous active low, clears the profile state and config registers to zero
module emergency_stop_scurve_profile_core #(
    parameter int unsigned FRAC_BITS   = 16,
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic signed [31:0] measured_velocity,
    input  logic signed [31:0] measured_accel,
    // output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic signed [31:0] velocity_command,
    output logic signed [31:0] accel_command,
    output logic        phase_one_done,
    output logic        phase_two_done,
    output logic        stop_complete,
    output logic [15:0] phase_one_ticks,
    output logic [15:0] phase_two_ticks,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [esp_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    esp_pkg::state_t state_reg, state_next;

    logic [30:0] first_jerk_reg, first_target_reg, boundary_reg;
    logic signed [31:0] final_speed_reg, second_accel_reg;

    logic latched_reg, latched_next;
    logic p1_reg, p1_next, p2_reg, p2_next, cpl_reg, cpl_next;
    logic signed [31:0] tgt_reg, tgt_next, ra1_reg, ra1_next, ra2_reg, ra2_next;
    logic signed [31:0] vel_reg, vel_next, acc_reg, acc_next, bnd_reg, bnd_next;
    logic [COUNT_WIDTH-1:0] cnt1_reg, cnt1_next, cnt2_reg, cnt2_next;
    logic [63:0] sq_reg, sq_next;
    logic div_run_reg, div_run_next;

    logic in_xfer, out_xfer;
    logic div_start, div_done;
    logic [63:0] div_q;
    logic [32:0] den;
    logic [31:0] tmag;

    // working values for the tick
    logic signed [31:0] w_tgt, w_ra1, w_vel, w_bnd, w_ra2;
    logic signed [33:0] diff, d1, d2, bsx, jsx, j2sx;
    logic [31:0] jmag;

    assign pready   = 1'b1;
    assign in_stall = (state_reg != esp_pkg::ST_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    assign out_valid = (state_reg == esp_pkg::ST_RESULT);
    assign out_xfer = out_valid && !out_stall;

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_jerk_reg   <= '0;
            first_target_reg <= '0;
            boundary_reg     <= '0;
            final_speed_reg  <= '0;
            second_accel_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr)
                esp_pkg::ADDR_FIRST_JERK:   first_jerk_reg   <= pwdata[30:0];
                esp_pkg::ADDR_FIRST_TARGET: first_target_reg <= pwdata[30:0];
                esp_pkg::ADDR_BOUNDARY:     boundary_reg     <= pwdata[30:0];
                esp_pkg::ADDR_FINAL_SPEED:  final_speed_reg  <= pwdata;
                esp_pkg::ADDR_SECOND_ACCEL: second_accel_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr)
            esp_pkg::ADDR_FIRST_JERK:   prdata = {1'b0, first_jerk_reg};
            esp_pkg::ADDR_FIRST_TARGET: prdata = {1'b0, first_target_reg};
            esp_pkg::ADDR_BOUNDARY:     prdata = {1'b0, boundary_reg};
            esp_pkg::ADDR_FINAL_SPEED:  prdata = final_speed_reg;
            esp_pkg::ADDR_SECOND_ACCEL: prdata = second_accel_reg;
            default:                    prdata = '0;
        endcase
    end

    // divider for the phase-two jerk
    assign tmag = tgt_reg[31] ? 32'(-tgt_reg) : 32'(tgt_reg);
    assign den  = {(bnd_reg[31] ? 32'(-bnd_reg) : 32'(bnd_reg)), 1'b0};

    esp_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sq_reg),
        .divisor  (den),
        .done     (div_done),
        .quotient (div_q)
    );

    // sequencer and tick update
    always_comb
    begin
        state_next   = state_reg;
        latched_next = latched_reg;
        p1_next = p1_reg;  p2_next = p2_reg;  cpl_next = cpl_reg;
        tgt_next = tgt_reg; ra1_next = ra1_reg; ra2_next = ra2_reg;
        vel_next = vel_reg; acc_next = acc_reg; bnd_next = bnd_reg;
        cnt1_next = cnt1_reg; cnt2_next = cnt2_reg;
        sq_next   = sq_reg;
        div_start = 1'b0;
        w_tgt = tgt_reg; w_ra1 = ra1_reg; w_vel = vel_reg; w_bnd = bnd_reg;
        w_ra2 = ra2_reg;
        diff = '0; d1 = '0; d2 = '0; jmag = '0;
        bsx  = {3'b000, boundary_reg};
        jsx  = {3'b000, first_jerk_reg};
        j2sx = '0;
        unique case (state_reg)
            esp_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (action)
                    begin
                        latched_next = 1'b0;
                        p1_next = 1'b0; p2_next = 1'b0; cpl_next = 1'b0;
                        tgt_next = '0; ra1_next = '0; ra2_next = '0;
                        vel_next = '0; acc_next = '0; bnd_next = '0;
                        cnt1_next = '0; cnt2_next = '0;
                        state_next = esp_pkg::ST_RESULT;
                    end
                    else
                    begin
                        if (!latched_reg)
                        begin
                            w_tgt = measured_velocity[31] ? $signed({1'b0, first_target_reg})
                                                          : -$signed({1'b0, first_target_reg});
                            w_ra1 = measured_accel;
                            w_vel = measured_velocity;
                            w_bnd = measured_velocity;
                            w_ra2 = w_tgt;
                        end
                        latched_next = 1'b1;
                        tgt_next = w_tgt; ra1_next = w_ra1; vel_next = w_vel;
                        bnd_next = w_bnd; ra2_next = w_ra2;
                        diff = 34'(final_speed_reg) - 34'(w_vel);
                        state_next = esp_pkg::ST_RESULT;
                        if (diff > bsx || diff < -bsx)
                        begin
                            d1 = 34'(w_tgt) - 34'(w_ra1);
                            if (d1 >= jsx || d1 <= -jsx)
                            begin
                                if (w_tgt >= w_ra1)
                                    w_ra1 = esp_pkg::sat32(34'(w_ra1) + jsx);
                                else
                                    w_ra1 = esp_pkg::sat32(34'(w_ra1) - jsx);
                            end
                            else
                            begin
                                p1_next = 1'b1;
                                w_ra1 = w_tgt;
                            end
                            ra1_next = w_ra1;
                            vel_next = esp_pkg::sat32(34'(w_vel) + 34'(w_ra1));
                            acc_next = w_ra1;
                            bnd_next = vel_next;
                            cnt1_next = (cnt1_reg == CNT_MAX) ? cnt1_reg
                                                              : cnt1_reg + 1'b1;
                            if (p2_reg)
                            begin
                                vel_next = final_speed_reg;
                                acc_next = '0;
                            end
                        end
                        else if (diff != 0)
                        begin
                            state_next = esp_pkg::ST_MUL;
                        end
                        else
                        begin
                            cpl_next = 1'b1;
                            acc_next = '0;
                            if (p2_reg)
                                vel_next = final_speed_reg;
                        end
                    end
                end
            end
            esp_pkg::ST_MUL:
            begin
                sq_next    = 64'(tmag) * 64'(tmag);
                state_next = esp_pkg::ST_DIV;
            end
            esp_pkg::ST_DIV:
            begin
                div_start = !div_run_reg;
                if (div_done)
                begin
                    if (bnd_reg == 0)
                        jmag = '0;
                    else if (div_q > 64'h7FFF_FFFF)
                        jmag = 32'h7FFF_FFFF;
                    else
                        jmag = div_q[31:0];
                    w_ra2 = ra2_reg;
                    if (jmag == 0 || jmag >= (32'd1 << FRAC_BITS))
                    begin
                        p2_next = 1'b1;
                        w_ra2 = second_accel_reg;
                    end
                    j2sx = {2'b00, jmag};
                    d2 = 34'(second_accel_reg) - 34'(w_ra2);
                    if (d2 >= j2sx || d2 <= -j2sx)
                    begin
                        if (second_accel_reg >= w_ra2)
                            w_ra2 = esp_pkg::sat32(34'(w_ra2) + j2sx);
                        else
                            w_ra2 = esp_pkg::sat32(34'(w_ra2) - j2sx);
                    end
                    else
                    begin
                        p2_next = 1'b1;
                        w_ra2 = second_accel_reg;
                    end
                    ra2_next = w_ra2;
                    vel_next = esp_pkg::sat32(34'(vel_reg) + 34'(w_ra2));
                    acc_next = w_ra2;
                    cnt2_next = (cnt2_reg == CNT_MAX) ? cnt2_reg : cnt2_reg + 1'b1;
                    if (p2_next)
                    begin
                        vel_next = final_speed_reg;
                        acc_next = '0;
                    end
                    state_next = esp_pkg::ST_RESULT;
                end
            end
            esp_pkg::ST_RESULT:
            begin
                if (out_xfer)
                    state_next = esp_pkg::ST_IDLE;
            end
            default: state_next = esp_pkg::ST_IDLE;
        endcase
    end

    // divider launch flag
    always_comb
    begin
        div_run_next = div_run_reg;
        if (state_reg == esp_pkg::ST_DIV && !div_run_reg)
            div_run_next = 1'b1;
        else if (div_done)
            div_run_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= esp_pkg::ST_IDLE;
            div_run_reg <= 1'b0;
            latched_reg <= 1'b0;
            p1_reg <= 1'b0; p2_reg <= 1'b0; cpl_reg <= 1'b0;
            tgt_reg <= '0; ra1_reg <= '0; ra2_reg <= '0;
            vel_reg <= '0; acc_reg <= '0; bnd_reg <= '0;
            cnt1_reg <= '0; cnt2_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            div_run_reg <= div_run_next;
            latched_reg <= latched_next;
            p1_reg <= p1_next; p2_reg <= p2_next; cpl_reg <= cpl_next;
            tgt_reg <= tgt_next; ra1_reg <= ra1_next; ra2_reg <= ra2_next;
            vel_reg <= vel_next; acc_reg <= acc_next; bnd_reg <= bnd_next;
            cnt1_reg <= cnt1_next; cnt2_reg <= cnt2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_reg <= sq_next;
    end

    // result fields
    assign velocity_command = vel_reg;
    assign accel_command    = acc_reg;
    assign phase_one_done   = p1_reg;
    assign phase_two_done   = p2_reg;
    assign stop_complete    = cpl_reg;
    assign phase_one_ticks  = (32'(cnt1_reg) > 32'hFFFF) ? 16'hFFFF : 16'(cnt1_reg);
    assign phase_two_ticks  = (32'(cnt2_reg) > 32'hFFFF) ? 16'hFFFF : 16'(cnt2_reg);

endmodule

[hw/rtl/esp_checker.sv]
`timescale 1ns / 1ps
// port-level checks on the profile core
module esp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        action,
    input logic        out_valid,
    input logic        out_stall,
    input logic signed [31:0] velocity_command,
    input logic        phase_two_done,
    input logic        stop_complete,
    input logic [15:0] phase_one_ticks
);

    // a rearm transfer leads to a valid result with zero velocity, flags and phase-one count
    a_rearm_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && action) |=>
            (out_valid && velocity_command == 0 && !phase_two_done && !stop_complete
             && phase_one_ticks == 0))
        else $error("rearm result not cleared");

    // no new input while a result is pending
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while result pending");

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(velocity_command)))
        else $error("stalled result changed");

    // an accepted transfer raises in_stall in the following cycle
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("ready after accept");

endmodule

bind emergency_stop_scurve_profile_core esp_checker u_esp_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .action           (action),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .velocity_command (velocity_command),
    .phase_two_done   (phase_two_done),
    .stop_complete    (stop_complete),
    .phase_one_ticks  (phase_one_ticks)
);
